### src/brf_pkg.sv
`default_nettype none

package brf_pkg;

  localparam int CAP_W  = 13;
  localparam int BYTE_W = 8;
  localparam int IDX_W  = 2;

  localparam logic [1:0] KIND_PUSH  = 2'd0;
  localparam logic [1:0] KIND_POP   = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [IDX_W-1:0] REG_DROP_NEWEST = 2'd0;
  localparam logic [IDX_W-1:0] REG_CAPACITY    = 2'd1;

  typedef struct packed {
    logic [1:0]        kind;
    logic [BYTE_W-1:0] data_in;
  } req_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_out;
    logic              done_res;
    logic              dropped;
    logic [CAP_W-1:0]  fill_level;
  } rsp_word_t;

  typedef struct packed {
    logic             pop_hit;
    logic             done_res;
    logic             dropped;
    logic [CAP_W-1:0] fill_level;
  } res_info_t;

endpackage

`default_nettype wire

### src/brf_ram.sv
`default_nettype none

module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### src/brf_ctrl.sv
`default_nettype none

module brf_ctrl #(
  parameter int DEPTH = 4096
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           accept,
  input  wire brf_pkg::req_word_t             req,
  input  wire logic                           cfg_we,
  input  wire logic [brf_pkg::IDX_W-1:0]      cfg_index,
  input  wire logic [brf_pkg::CAP_W-1:0]      cfg_data,
  output      logic                           mem_we,
  output      logic [$clog2(DEPTH)-1:0]       mem_waddr,
  output      logic [brf_pkg::BYTE_W-1:0]     mem_wdata,
  output      logic                           mem_re,
  output      logic [$clog2(DEPTH)-1:0]       mem_raddr,
  output      brf_pkg::res_info_t             info
);

  import brf_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [PTR_W-1:0] write_pos, write_pos_next;
  logic [PTR_W-1:0] read_pos, read_pos_next;
  logic [CNT_W-1:0] held_count, held_count_next;
  logic [CNT_W-1:0] capacity, cap_clamped;
  logic             drop_newest;
  logic             full, empty;
  logic [31:0]      cfg_wide;

  function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p,
                                                input logic [CNT_W-1:0] cap);
    logic [31:0] n;
    n = 32'(p) + 32'd1;
    return (n >= 32'(cap)) ? '0 : n[PTR_W-1:0];
  endfunction

  assign full  = held_count >= capacity;
  assign empty = held_count == '0;

  assign cfg_wide = 32'(cfg_data);
  always_comb begin
    if (cfg_wide == 32'd0) begin
      cap_clamped = CNT_W'(1);
    end else if (cfg_wide > 32'(DEPTH)) begin
      cap_clamped = CNT_W'(DEPTH);
    end else begin
      cap_clamped = cfg_wide[CNT_W-1:0];
    end
  end

  always_comb begin
    write_pos_next  = write_pos;
    read_pos_next   = read_pos;
    held_count_next = held_count;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    info.pop_hit    = 1'b0;
    info.done_res   = 1'b0;
    info.dropped    = 1'b0;
    case (req.kind)
      KIND_PUSH: begin
        if (full) begin
          info.dropped = 1'b1;
          if (!drop_newest) begin
            mem_we         = 1'b1;
            read_pos_next  = next_pos(read_pos, capacity);
            write_pos_next = next_pos(write_pos, capacity);
            info.done_res  = 1'b1;
          end
        end else begin
          mem_we          = 1'b1;
          write_pos_next  = next_pos(write_pos, capacity);
          held_count_next = held_count + CNT_W'(1);
          info.done_res   = 1'b1;
        end
      end
      KIND_POP: begin
        if (!empty) begin
          mem_re          = 1'b1;
          read_pos_next   = next_pos(read_pos, capacity);
          held_count_next = held_count - CNT_W'(1);
          info.done_res   = 1'b1;
          info.pop_hit    = 1'b1;
        end
      end
      KIND_CLEAR: begin
        write_pos_next  = '0;
        read_pos_next   = '0;
        held_count_next = '0;
      end
      default: begin
      end
    endcase
    mem_we = mem_we & accept;
    mem_re = mem_re & accept;
    info.fill_level = CAP_W'(held_count_next);
  end

  assign mem_waddr       = write_pos;
  assign mem_wdata       = req.data_in;
  assign mem_raddr       = read_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos   <= '0;
      read_pos    <= '0;
      held_count  <= '0;
      drop_newest <= 1'b0;
      capacity    <= CNT_W'(DEPTH);
    end else if (cfg_we) begin
      if (cfg_index == REG_DROP_NEWEST) begin
        drop_newest <= cfg_data[0];
      end else if (cfg_index == REG_CAPACITY) begin
        capacity   <= cap_clamped;
        write_pos  <= '0;
        read_pos   <= '0;
        held_count <= '0;
      end
    end else if (accept) begin
      write_pos  <= write_pos_next;
      read_pos   <= read_pos_next;
      held_count <= held_count_next;
    end
  end

endmodule

`default_nettype wire

### src/byte_ring_fifo_overflow_policy_unit.sv
// Channel  | Handshake              | Word
// ---------+------------------------+-----------------------------------------
// req      | req_valid / req_ready  | kind, data_in (push, pop or clear)
// rsp      | rsp_valid / rsp_ready  | data_out, done_res, dropped, fill_level
// cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data (register write)
//
// One word is accepted per cycle while req_ready is high. The store's read is
// registered, and the output register loads the result as the read stage
// advances. Reset is synchronous: it clears pointers, count, drop_newest and
// valid flags, not the store, and sets capacity to DEPTH. req_ready drops
// while the read stage and a stalled output register are both full, or while
// a register write waits. cfg_ready is high only when no word is in flight.
`default_nettype none

module byte_ring_fifo_overflow_policy_unit #(
  parameter int DEPTH = 4096
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      req_valid,
  output      logic                      req_ready,
  input  wire brf_pkg::req_word_t        req,
  output      logic                      rsp_valid,
  input  wire logic                      rsp_ready,
  output      brf_pkg::rsp_word_t        rsp,
  input  wire logic                      cfg_valid,
  output      logic                      cfg_ready,
  input  wire logic [brf_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [brf_pkg::CAP_W-1:0] cfg_data
);

  import brf_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);

  logic              accept, out_load, s1_valid;
  res_info_t         info, s1_info;
  logic              mem_we, mem_re;
  logic [PTR_W-1:0]  mem_waddr, mem_raddr;
  logic [BYTE_W-1:0] mem_wdata, mem_rdata;

  assign cfg_ready = !s1_valid && !rsp_valid;
  assign out_load  = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = (!s1_valid || out_load) && !cfg_valid;
  assign accept    = req_valid && req_ready;

  brf_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .req       (req),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .info      (info)
  );

  brf_ram #(.WIDTH(BYTE_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_info <= info;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.data_out   <= s1_info.pop_hit ? mem_rdata : '0;
      rsp.done_res   <= s1_info.done_res;
      rsp.dropped    <= s1_info.dropped;
      rsp.fill_level <= s1_info.fill_level;
    end
  end

  a_data_needs_done: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.data_out != '0) |-> rsp.done_res)
    else $error("nonzero data_out on a result that did not take effect");

  a_drop_new_when_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.dropped && !rsp.done_res |-> rsp.fill_level != '0)
    else $error("byte discarded while the FIFO was not full");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted word lost before the read stage");

  a_full_pipe_stalls: assert property (@(posedge clk) disable iff (rst)
    s1_valid && rsp_valid && !rsp_ready |-> !req_ready)
    else $error("word accepted while both stages are blocked");

endmodule

`default_nettype wire
